// ===== design/ptmq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmq_pkg: shared types and constants for the per-task mailbox queues
// Holds the beat structs, opcodes, status codes, states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package ptmq_pkg;

  localparam int NUM_TASKS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [15:0] MAX_SIZE_RST = 16'd4096;
  localparam logic [7:0]  PTR_KIND_RST = 8'd1;

  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_PSEND = 3'd1;
  localparam logic [2:0] OP_RECV  = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_REJ   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [0:0] REG_MAX_SIZE = 1'b0;
  localparam logic [0:0] REG_PTR_KIND = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  sender_task;
    logic [7:0]  target_task;
    logic [7:0]  message_kind;
    logic [31:0] payload_word;
    logic [15:0] payload_size;
    logic [31:0] now_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  got_sender;
    logic [7:0]  got_receiver;
    logic [7:0]  got_kind;
    logic [31:0] got_payload;
    logic [15:0] got_size;
    logic [31:0] got_timestamp;
    logic [4:0]  queued_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_BCAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_issue;
    logic rd_finish;
    logic bc_init;
    logic bc_step;
    logic bc_finish;
    logic done;
  } ctrl_t;

  typedef struct packed {
    logic is_bcast;
    logic is_recv_hit;
    logic bc_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/ptmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptmq_ctrl: sequencer for the mailbox queues
// Steps one command through execute, memory read and broadcast walk states.
// ----------------------------------------------------------------------------
`default_nettype none
module ptmq_ctrl import ptmq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output ctrl_t      ctrl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_bcast) begin
          ctrl.bc_init = 1'b1;
          state_nxt = S_BCAST;
        end else if (stat.is_recv_hit) begin
          ctrl.rd_issue = 1'b1;
          state_nxt = S_READ;
        end else begin
          ctrl.exec = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        ctrl.rd_finish = 1'b1;
        state_nxt = S_DONE;
      end
      S_BCAST: begin
        ctrl.bc_step = 1'b1;
        if (stat.bc_last) begin
          ctrl.bc_finish = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ctrl.done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/ptmq_dp.sv =====
// ----------------------------------------------------------------------------
// ptmq_dp: mailbox datapath
// Per-task ring pointers and fill counts, slot memory, and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none
module ptmq_dp import ptmq_pkg::*; #(
  parameter int NUM_TASKS   = NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_t     ctrl,
  input  wire in_beat_t  in_beat,
  input  wire logic [15:0] max_size,
  input  wire logic [7:0]  ptr_kind,
  output stat_t          stat,
  output out_beat_t      out_beat
);
  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SD = NUM_TASKS * (2 ** QW);

  in_beat_t cmd_r;
  logic [NUM_TASKS-1:0] exists_r;
  logic [FW-1:0] fill_r [NUM_TASKS];
  logic [QW-1:0] head_r [NUM_TASKS];
  logic [QW-1:0] tail_r [NUM_TASKS];
  logic [63:0] mem_hdr [SD];
  logic [31:0] mem_time [SD];
  logic [63:0] rd_hdr_r;
  logic [31:0] rd_time_r;
  logic [TW-1:0] bc_idx_r;
  logic bc_any_r;
  logic [1:0] status_r;
  logic [4:0] count_r;

  logic in_range, bcast, is_full, wr_en;
  logic [TW-1:0] tgt, wt;
  logic [7:0] wr_kind;
  logic bc_do;

  assign in_range = ({24'd0, cmd_r.target_task} < NUM_TASKS);
  assign tgt = cmd_r.target_task[TW-1:0];
  assign bcast = (cmd_r.opcode == OP_SEND) && (cmd_r.target_task == 8'd0)
               && !(cmd_r.payload_size > max_size);
  assign stat.is_bcast = bcast;
  assign stat.is_recv_hit = (cmd_r.opcode == OP_RECV) && in_range && (fill_r[tgt] != '0);
  assign stat.bc_last = (bc_idx_r == TW'(NUM_TASKS - 1));

  assign bc_do = ctrl.bc_step && ({{(32-TW){1'b0}}, bc_idx_r} != {24'd0, cmd_r.sender_task})
               && exists_r[bc_idx_r];
  assign wt = ctrl.bc_step ? bc_idx_r : tgt;
  assign is_full = (fill_r[wt] >= FW'(QUEUE_DEPTH));
  assign wr_kind = (cmd_r.opcode == OP_PSEND) ? ptr_kind : cmd_r.message_kind;
  assign wr_en = !is_full && (bc_do || (ctrl.exec && in_range &&
                 ((cmd_r.opcode == OP_PSEND) ||
                  (cmd_r.opcode == OP_SEND && !(cmd_r.payload_size > max_size)))));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_beat;
    end
    if (wr_en) begin
      mem_hdr[{wt, tail_r[wt]}] <= {cmd_r.payload_word, cmd_r.payload_size,
                                    wr_kind, cmd_r.sender_task};
      mem_time[{wt, tail_r[wt]}] <= cmd_r.now_ticks;
    end
    if (ctrl.rd_issue) begin
      rd_hdr_r <= mem_hdr[{tgt, head_r[tgt]}];
      rd_time_r <= mem_time[{tgt, head_r[tgt]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exists_r <= '0;
      bc_idx_r <= '0;
      bc_any_r <= 1'b0;
      status_r <= ST_OK;
      count_r <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        tail_r[wt] <= (tail_r[wt] == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[wt] + 1'b1;
        fill_r[wt] <= fill_r[wt] + 1'b1;
      end
      if (bc_do) begin
        exists_r[wt] <= 1'b1;
      end
      if (ctrl.bc_init) begin
        bc_idx_r <= TW'(1);
        bc_any_r <= 1'b0;
      end
      if (ctrl.bc_step) begin
        bc_idx_r <= bc_idx_r + 1'b1;
        if (wr_en) begin
          bc_any_r <= 1'b1;
        end
      end
      if (ctrl.bc_finish) begin
        status_r <= (bc_any_r || wr_en) ? ST_OK : ST_REJ;
        count_r <= '0;
      end
      if (ctrl.rd_issue) begin
        exists_r[tgt] <= 1'b1;
        head_r[tgt] <= (head_r[tgt] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r[tgt] + 1'b1;
        fill_r[tgt] <= fill_r[tgt] - 1'b1;
        status_r <= ST_OK;
        count_r <= '0;
      end
      if (ctrl.exec) begin
        count_r <= (cmd_r.opcode == OP_COUNT && in_range && exists_r[tgt]) ?
                   5'(fill_r[tgt]) : '0;
        unique case (cmd_r.opcode)
          OP_SEND: begin
            if (in_range && !(cmd_r.payload_size > max_size)) begin
              exists_r[tgt] <= 1'b1;
              status_r <= is_full ? ST_REJ : ST_OK;
            end else begin
              status_r <= ST_REJ;
            end
          end
          OP_PSEND: begin
            if (in_range) begin
              exists_r[tgt] <= 1'b1;
              status_r <= is_full ? ST_REJ : ST_OK;
            end else begin
              status_r <= ST_REJ;
            end
          end
          OP_RECV: begin
            if (in_range) begin
              exists_r[tgt] <= 1'b1;
              status_r <= ST_EMPTY;
            end else begin
              status_r <= ST_REJ;
            end
          end
          OP_COUNT: begin
            status_r <= ST_OK;
          end
          OP_CLEAR: begin
            status_r <= ST_OK;
            if (in_range && exists_r[tgt]) begin
              head_r[tgt] <= tail_r[tgt];
              fill_r[tgt] <= '0;
            end
          end
          default: status_r <= ST_REJ;
        endcase
      end
    end
  end

  logic hit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.rd_issue) begin
      hit_r <= 1'b1;
    end else if (ctrl.exec || ctrl.bc_init) begin
      hit_r <= 1'b0;
    end
  end

  always_comb begin
    out_beat = '0;
    out_beat.status = status_r;
    out_beat.queued_count = count_r;
    if (hit_r) begin
      out_beat.got_sender = rd_hdr_r[7:0];
      out_beat.got_kind = rd_hdr_r[15:8];
      out_beat.got_size = rd_hdr_r[31:16];
      out_beat.got_payload = rd_hdr_r[63:32];
      out_beat.got_receiver = cmd_r.target_task;
      out_beat.got_timestamp = rd_time_r;
    end
    if (ctrl.rd_finish) begin
      out_beat.got_sender = 8'd0;
    end
  end
endmodule
`default_nettype wire

// ===== design/per_task_mailbox_queues.sv =====
// ----------------------------------------------------------------------------
// per_task_mailbox_queues: per-task ring mailboxes with broadcast
//
// Channel   Direction  Handshake
// in_       input      start high while busy low takes one beat
// out_      output     out_valid marks one beat for one cycle
// cfg_      input      APB write, register 0 at 0x0, register 1 at 0x4
//
// Send, pointer send, count, clear and empty receive go from the execute
// state to the done state, which raises out_valid; a receive that pops a
// message adds a read state (slot memory read). A broadcast walks
// mailboxes 1 to NUM_TASKS-1, one per cycle, in its own state. busy drops
// in the cycle after out_valid. Reset is synchronous and clears all
// mailbox state at once. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
`default_nettype none
module per_task_mailbox_queues import ptmq_pkg::*; #(
  parameter int NUM_TASKS   = NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  output out_beat_t      out_beat,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  logic [15:0] max_size_r;
  logic [7:0]  ptr_kind_r;
  ctrl_t ctrl;
  stat_t stat;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
      ptr_kind_r <= PTR_KIND_RST;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_MAX_SIZE) begin
        max_size_r <= pwdata[15:0];
      end else begin
        ptr_kind_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_PTR_KIND) begin
        prdata = {24'd0, ptr_kind_r};
      end else begin
        prdata = {16'd0, max_size_r};
      end
    end
  end

  ptmq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .busy(busy), .ctrl(ctrl)
  );

  ptmq_dp #(.NUM_TASKS(NUM_TASKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .in_beat(in_beat),
    .max_size(max_size_r), .ptr_kind(ptr_kind_r), .stat(stat), .out_beat(out_beat)
  );

  assign out_valid = ctrl.done;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("controller did not return to idle");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.status != 2'd3) else $error("bad status code");
`endif
endmodule
`default_nettype wire
